[src/ttcw_pkg.sv]
// ttcw_pkg: shared types, constants and codes of the terminal cell writer
// no dependencies; compiled first

package ttcw_pkg;

  // screen store geometry
  localparam int MAX_COLUMNS = 128;
  localparam int MAX_ROWS    = 64;
  localparam int TAB_WIDTH   = 8;
  localparam int COL_BITS    = 7;
  localparam int ROW_BITS    = 6;
  localparam int ADDR_BITS   = ROW_BITS + COL_BITS;
  localparam int CELL_DEPTH  = MAX_ROWS * MAX_COLUMNS;

  // register reset values
  localparam logic [7:0]  COLUMN_COUNT_RST = 8'd80;
  localparam logic [6:0]  ROW_COUNT_RST    = 7'd24;
  localparam logic [31:0] FG_RST           = 32'hFFF8_F8F2;
  localparam logic [7:0]  ATTR_RST         = 8'h00;

  // geometry limits
  localparam logic [7:0] COLS_MIN = 8'd2;
  localparam logic [7:0] COLS_MAX = 8'(MAX_COLUMNS);
  localparam logic [6:0] ROWS_MIN = 7'd1;
  localparam logic [6:0] ROWS_MAX = 7'(MAX_ROWS);

  // byte and control codes
  localparam logic [7:0] ESC_BYTE = 8'h1b;
  localparam logic [7:0] CTL_BS   = 8'h08;
  localparam logic [7:0] CTL_TAB  = 8'h09;
  localparam logic [7:0] CTL_NL   = 8'h0a;
  localparam logic [7:0] CTL_NONE = 8'h80;

  // action codes
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef enum logic [1:0] {
    CFG_COLUMN_COUNT = 2'd0,
    CFG_ROW_COUNT    = 2'd1,
    CFG_CURRENT_FG   = 2'd2,
    CFG_CURRENT_ATTR = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic [15:0] code;
    logic [31:0] fg;
    logic [7:0]  attr;
  } cell_t;

  localparam int CELL_BITS = $bits(cell_t);

  // result of taking one byte
  typedef struct packed {
    logic                wr;
    logic [15:0]         code;
    logic [ROW_BITS-1:0] wr_row;
    logic [COL_BITS-1:0] wr_col;
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
    logic [1:0]          pend;
    logic [15:0]         partial;
    logic                scroll;
  } step_t;

  function automatic logic [ADDR_BITS-1:0] cell_addr(
    input logic [ROW_BITS-1:0] row,
    input logic [COL_BITS-1:0] col
  );
    cell_addr = {row, col};
  endfunction

endpackage

[src/ttcw_if.sv]
// ttcw_in_if / ttcw_out_if: valid-ready channels of the terminal cell writer
// depends on ttcw_pkg for widths

interface ttcw_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [7:0]                   byte_in;
  logic [ttcw_pkg::ROW_BITS-1:0] read_row;
  logic [ttcw_pkg::COL_BITS-1:0] read_col;

  modport source (output valid, action, byte_in, read_row, read_col, input ready);
  modport sink   (input valid, action, byte_in, read_row, read_col, output ready);
endinterface

interface ttcw_out_if;
  logic                         valid;
  logic                         ready;
  logic [ttcw_pkg::COL_BITS-1:0] cursor_col_out;
  logic [ttcw_pkg::ROW_BITS-1:0] cursor_row_out;
  logic [15:0]                  cell_codepoint;
  logic [31:0]                  cell_fg;
  logic [7:0]                   cell_attributes;
  logic                         read_valid;

  modport source (output valid, cursor_col_out, cursor_row_out, cell_codepoint, cell_fg,
                  cell_attributes, read_valid, input ready);
  modport sink   (input valid, cursor_col_out, cursor_row_out, cell_codepoint, cell_fg,
                  cell_attributes, read_valid, output ready);
endinterface

[src/ttcw_ram.sv]
// ttcw_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module ttcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[src/ttcw_step.sv]
// ttcw_step: utf-8 decode and cursor motion for one host byte
// depends on ttcw_pkg

module ttcw_step (
  input  logic [7:0]                    byte_i,
  input  logic [1:0]                    pend_i,
  input  logic [15:0]                   partial_i,
  input  logic [ttcw_pkg::COL_BITS-1:0] col_i,
  input  logic [ttcw_pkg::ROW_BITS-1:0] row_i,
  input  logic [7:0]                    cols_i,
  input  logic [6:0]                    rows_i,
  output ttcw_pkg::step_t               step_o
);

  logic [ttcw_pkg::COL_BITS-1:0] col_c;
  logic [ttcw_pkg::ROW_BITS-1:0] row_c;
  logic [7:0]                    cols_m1;
  logic [6:0]                    rows_m1;
  logic                          put;
  logic [7:0]                    ctl;
  logic [15:0]                   code;
  logic [15:0]                   part_cont;
  logic [7:0]                    tab_pos;
  logic [6:0]                    row_w;
  logic [ttcw_pkg::COL_BITS-1:0] col_w;

  assign cols_m1 = cols_i - 8'd1;
  assign rows_m1 = rows_i - 7'd1;

  // cursor pulled back into the area in use
  assign col_c = ({1'b0, col_i} > cols_m1) ? cols_m1[ttcw_pkg::COL_BITS-1:0] : col_i;
  assign row_c = ({1'b0, row_i} > rows_m1) ? rows_m1[ttcw_pkg::ROW_BITS-1:0] : row_i;

  assign part_cont = {partial_i[9:0], byte_i[5:0]};

  // next tab stop
  assign tab_pos = 8'(((8'({1'b0, col_c}) / 8'(ttcw_pkg::TAB_WIDTH)) + 8'd1)
                   * 8'(ttcw_pkg::TAB_WIDTH));

  // utf-8 decode
  always_comb begin
    step_o         = '0;
    step_o.pend    = pend_i;
    step_o.partial = partial_i;
    put            = 1'b0;
    ctl            = ttcw_pkg::CTL_NONE;
    code           = '0;
    if (pend_i != 2'd0) begin
      step_o.partial = part_cont;
      step_o.pend    = pend_i - 2'd1;
      put            = (pend_i == 2'd1);
      code           = part_cont;
    end else if (byte_i == ttcw_pkg::ESC_BYTE) begin
      put = 1'b0;
    end else if (!byte_i[7]) begin
      put  = 1'b1;
      ctl  = byte_i;
      code = {8'h00, byte_i};
    end else if (byte_i[7:5] == 3'b110) begin
      step_o.partial = {11'd0, byte_i[4:0]};
      step_o.pend    = 2'd1;
    end else if (byte_i[7:4] == 4'b1110) begin
      step_o.partial = {12'd0, byte_i[3:0]};
      step_o.pend    = 2'd2;
    end else begin
      put = 1'b1;
    end

    // cursor motion after a stored cell
    row_w = {1'b0, row_c};
    col_w = col_c;
    if (put) begin
      case (ctl)
        ttcw_pkg::CTL_BS: begin
          col_w = (col_c == '0) ? '0 : col_c - 1'b1;
        end
        ttcw_pkg::CTL_TAB: begin
          col_w = (tab_pos > cols_m1) ? cols_m1[ttcw_pkg::COL_BITS-1:0]
                                      : tab_pos[ttcw_pkg::COL_BITS-1:0];
        end
        default: begin
          if (ctl == ttcw_pkg::CTL_NL || {1'b0, col_c} > (cols_i - 8'd2)) begin
            row_w = {1'b0, row_c} + 7'd1;
            col_w = '0;
          end else begin
            col_w = col_c + 1'b1;
          end
        end
      endcase
    end

    step_o.wr     = put;
    step_o.code   = code;
    step_o.wr_row = row_c;
    step_o.wr_col = col_c;
    step_o.col    = col_w;
    step_o.row    = row_w[ttcw_pkg::ROW_BITS-1:0];
    // past the last row: scroll up, cursor to start of last row
    if (row_w >= rows_i) begin
      step_o.scroll = 1'b1;
      step_o.col    = '0;
      step_o.row    = rows_m1[ttcw_pkg::ROW_BITS-1:0];
    end
  end

endmodule

[src/text_terminal_cell_writer_core.sv]
// Terminal cell writer. After reset the screen store (8192 cells) is swept to zero,
// one cell per cycle, so no word is taken until the sweep is done; configuration
// writes are taken throughout. A byte word that needs no scroll writes at most one
// cell and loads its result in the cycle it is taken. A read word passes through the
// read state because of the registered read port of the screen ram. With two or more
// rows, a byte that moves the cursor past the last row copies the rows up through the
// single read and write port of the ram, one cell a cycle. A result word is held in an
// output register; the next word is taken while that result is being taken.
// depends on ttcw_pkg, ttcw_if, ttcw_ram and ttcw_step

module text_terminal_cell_writer_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  ttcw_in_if.sink       in_i,
  ttcw_out_if.source    out_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [31:0]   cfg_data_i
);

  localparam int CLR_BITS = $clog2(ttcw_pkg::CELL_DEPTH);

  // configuration registers
  logic [7:0]  column_count_q;
  logic [6:0]  row_count_q;
  logic [31:0] current_fg_q;
  logic [7:0]  current_attr_q;

  // control state
  ttcw_pkg::state_e              state_q, state_d;
  logic [ttcw_pkg::COL_BITS-1:0] cur_col_q, cur_col_d;
  logic [ttcw_pkg::ROW_BITS-1:0] cur_row_q, cur_row_d;
  logic [1:0]                    pend_q, pend_d;
  logic [15:0]                   partial_q, partial_d;
  logic [CLR_BITS-1:0]           clr_q, clr_d;
  logic [ttcw_pkg::ROW_BITS-1:0] scr_row_q, scr_row_d;
  logic [ttcw_pkg::COL_BITS-1:0] scr_col_q, scr_col_d;
  logic                          cp_wr_q, cp_wr_d;
  logic [ttcw_pkg::ADDR_BITS-1:0] cp_addr_q, cp_addr_d;
  logic                          out_valid_q, out_valid_d;

  // output payload
  logic [ttcw_pkg::COL_BITS-1:0] out_col_q;
  logic [ttcw_pkg::ROW_BITS-1:0] out_row_q;
  ttcw_pkg::cell_t               out_cell_q;
  logic                          out_rv_q;

  logic                          load;
  logic [ttcw_pkg::COL_BITS-1:0] load_col;
  logic [ttcw_pkg::ROW_BITS-1:0] load_row;
  ttcw_pkg::cell_t               load_cell;
  logic                          load_rv;

  logic [7:0]      cols;
  logic [6:0]      rows;
  logic            accept;
  ttcw_pkg::step_t step;

  // ram ports
  logic                           ram_we;
  logic [ttcw_pkg::ADDR_BITS-1:0] ram_waddr;
  ttcw_pkg::cell_t                ram_wdata;
  logic                           ram_re;
  logic [ttcw_pkg::ADDR_BITS-1:0] ram_raddr;
  ttcw_pkg::cell_t                ram_rdata;

  // geometry in use
  always_comb begin
    cols = column_count_q;
    if (column_count_q > ttcw_pkg::COLS_MAX) cols = ttcw_pkg::COLS_MAX;
    if (column_count_q < ttcw_pkg::COLS_MIN) cols = ttcw_pkg::COLS_MIN;
    rows = row_count_q;
    if (row_count_q > ttcw_pkg::ROWS_MAX) rows = ttcw_pkg::ROWS_MAX;
    if (row_count_q < ttcw_pkg::ROWS_MIN) rows = ttcw_pkg::ROWS_MIN;
  end

  ttcw_step u_step (
    .byte_i    (in_i.byte_in),
    .pend_i    (pend_q),
    .partial_i (partial_q),
    .col_i     (cur_col_q),
    .row_i     (cur_row_q),
    .cols_i    (cols),
    .rows_i    (rows),
    .step_o    (step)
  );

  ttcw_ram #(
    .WIDTH (ttcw_pkg::CELL_BITS),
    .DEPTH (ttcw_pkg::CELL_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready = (state_q == ttcw_pkg::ST_IDLE) && (!out_valid_q || out_o.ready);
  assign accept     = in_i.valid && in_i.ready;

  // sequencer: next state, ram control and result loading
  always_comb begin
    state_d     = state_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    pend_d      = pend_q;
    partial_d   = partial_q;
    clr_d       = clr_q;
    scr_row_d   = scr_row_q;
    scr_col_d   = scr_col_q;
    cp_wr_d     = 1'b0;
    cp_addr_d   = cp_addr_q;
    out_valid_d = out_valid_q && !out_o.ready;
    load        = 1'b0;
    load_col    = cur_col_q;
    load_row    = cur_row_q;
    load_cell   = '0;
    load_rv     = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = cp_addr_q;
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = ttcw_pkg::cell_addr(in_i.read_row, in_i.read_col);

    // copy write follows the copy read in the next cycle
    if (cp_wr_q) begin
      ram_we = 1'b1;
    end

    case (state_q)
      ttcw_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == CLR_BITS'(ttcw_pkg::CELL_DEPTH - 1)) begin
          state_d = ttcw_pkg::ST_IDLE;
        end
      end
      ttcw_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_i.action == ttcw_pkg::ACT_READ) begin
            ram_re  = 1'b1;
            state_d = ttcw_pkg::ST_READ;
          end else begin
            cur_col_d = step.col;
            cur_row_d = step.row;
            pend_d    = step.pend;
            partial_d = step.partial;
            if (step.wr) begin
              ram_we    = 1'b1;
              ram_waddr = ttcw_pkg::cell_addr(step.wr_row, step.wr_col);
              ram_wdata = '{code: step.code, fg: current_fg_q, attr: current_attr_q};
            end
            if (step.scroll && rows > 7'd1) begin
              scr_row_d = ttcw_pkg::ROW_BITS'(1);
              scr_col_d = '0;
              state_d   = ttcw_pkg::ST_SCROLL;
            end else begin
              load     = 1'b1;
              load_col = step.col;
              load_row = step.row;
            end
          end
        end
      end
      ttcw_pkg::ST_READ: begin
        load      = 1'b1;
        load_cell = ram_rdata;
        load_rv   = 1'b1;
        state_d   = ttcw_pkg::ST_IDLE;
      end
      ttcw_pkg::ST_SCROLL: begin
        ram_re    = 1'b1;
        ram_raddr = ttcw_pkg::cell_addr(scr_row_q, scr_col_q);
        cp_wr_d   = 1'b1;
        cp_addr_d = ttcw_pkg::cell_addr(scr_row_q - 1'b1, scr_col_q);
        if ({1'b0, scr_col_q} == cols - 8'd1) begin
          scr_col_d = '0;
          if ({1'b0, scr_row_q} == rows - 7'd1) begin
            state_d = ttcw_pkg::ST_DRAIN;
          end else begin
            scr_row_d = scr_row_q + 1'b1;
          end
        end else begin
          scr_col_d = scr_col_q + 1'b1;
        end
      end
      ttcw_pkg::ST_DRAIN: begin
        load    = 1'b1;
        state_d = ttcw_pkg::ST_IDLE;
      end
      default: begin
        state_d = ttcw_pkg::ST_IDLE;
      end
    endcase

    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ttcw_pkg::ST_CLEAR;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      pend_q      <= '0;
      partial_q   <= '0;
      clr_q       <= '0;
      scr_row_q   <= '0;
      scr_col_q   <= '0;
      cp_wr_q     <= 1'b0;
      cp_addr_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      pend_q      <= pend_d;
      partial_q   <= partial_d;
      clr_q       <= clr_d;
      scr_row_q   <= scr_row_d;
      scr_col_q   <= scr_col_d;
      cp_wr_q     <= cp_wr_d;
      cp_addr_q   <= cp_addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_count_q <= ttcw_pkg::COLUMN_COUNT_RST;
      row_count_q    <= ttcw_pkg::ROW_COUNT_RST;
      current_fg_q   <= ttcw_pkg::FG_RST;
      current_attr_q <= ttcw_pkg::ATTR_RST;
    end else if (cfg_we_i) begin
      case (ttcw_pkg::cfg_idx_e'(cfg_idx_i))
        ttcw_pkg::CFG_COLUMN_COUNT: column_count_q <= cfg_data_i[7:0];
        ttcw_pkg::CFG_ROW_COUNT:    row_count_q    <= cfg_data_i[6:0];
        ttcw_pkg::CFG_CURRENT_FG:   current_fg_q   <= cfg_data_i;
        ttcw_pkg::CFG_CURRENT_ATTR: current_attr_q <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_col_q  <= load_col;
      out_row_q  <= load_row;
      out_cell_q <= load_cell;
      out_rv_q   <= load_rv;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.cursor_col_out  = out_col_q;
  assign out_o.cursor_row_out  = out_row_q;
  assign out_o.cell_codepoint  = out_cell_q.code;
  assign out_o.cell_fg         = out_cell_q.fg;
  assign out_o.cell_attributes = out_cell_q.attr;
  assign out_o.read_valid      = out_rv_q;

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// tb: self-checking bench for text_terminal_cell_writer_core, with a screen predictor
// in a small scoreboard class and plain tasks that drive the word and config ports
// depends on ttcw_pkg, ttcw_if and the core with its sub-blocks

module tb;

  localparam int STALL_LIMIT     = 60000;
  localparam int IDLE_GAP        = 16;
  localparam int WORDS_PER_PHASE = 66;

  typedef struct packed {
    logic                          action;
    logic [7:0]                    byte_in;
    logic [ttcw_pkg::ROW_BITS-1:0] read_row;
    logic [ttcw_pkg::COL_BITS-1:0] read_col;
  } word_t;

  typedef struct packed {
    logic [ttcw_pkg::COL_BITS-1:0] col;
    logic [ttcw_pkg::ROW_BITS-1:0] row;
    logic [15:0]                   code;
    logic [31:0]                   fg;
    logic [7:0]                    attr;
    logic                          rvalid;
  } result_t;

  // screen predictor and queue of expected result words
  class screen_scoreboard;
    logic [7:0]      col_reg;
    logic [6:0]      row_reg;
    logic [31:0]     fg_reg;
    logic [7:0]      attr_reg;
    int              cur_col;
    int              cur_row;
    int              pend;
    logic [15:0]     partial;
    ttcw_pkg::cell_t glyphs [ttcw_pkg::CELL_DEPTH];
    result_t         expected_q [$];
    int              errors;
    int              n_bytes;
    int              n_reads;
    int              n_scrolls;
    int              n_checked;

    function new();
      col_reg  = ttcw_pkg::COLUMN_COUNT_RST;
      row_reg  = ttcw_pkg::ROW_COUNT_RST;
      fg_reg   = ttcw_pkg::FG_RST;
      attr_reg = ttcw_pkg::ATTR_RST;
      cur_col  = 0;
      cur_row  = 0;
      pend     = 0;
      partial  = '0;
      foreach (glyphs[i]) glyphs[i] = '0;
    endfunction

    function void set_reg(ttcw_pkg::cfg_idx_e idx, logic [31:0] data);
      case (idx)
        ttcw_pkg::CFG_COLUMN_COUNT: col_reg  = data[7:0];
        ttcw_pkg::CFG_ROW_COUNT:    row_reg  = data[6:0];
        ttcw_pkg::CFG_CURRENT_FG:   fg_reg   = data;
        ttcw_pkg::CFG_CURRENT_ATTR: attr_reg = data[7:0];
        default: ;
      endcase
    endfunction

    function int cols_used();
      int c;
      c = col_reg;
      if (c > ttcw_pkg::MAX_COLUMNS) c = ttcw_pkg::MAX_COLUMNS;
      if (c < 2) c = 2;
      return c;
    endfunction

    function int rows_used();
      int r;
      r = row_reg;
      if (r > ttcw_pkg::MAX_ROWS) r = ttcw_pkg::MAX_ROWS;
      if (r < 1) r = 1;
      return r;
    endfunction

    // store a glyph at the cursor, then move the cursor and scroll if needed
    function void put_and_move(logic [15:0] code, logic [7:0] ctl);
      int cols;
      int rows;
      cols = cols_used();
      rows = rows_used();
      glyphs[cur_row * ttcw_pkg::MAX_COLUMNS + cur_col] = {code, fg_reg, attr_reg};
      if (ctl == ttcw_pkg::CTL_BS) begin
        if (cur_col > 0) cur_col--;
      end else if (ctl == ttcw_pkg::CTL_TAB) begin
        cur_col = (cur_col / ttcw_pkg::TAB_WIDTH + 1) * ttcw_pkg::TAB_WIDTH;
        if (cur_col > cols - 1) cur_col = cols - 1;
      end else if (ctl == ttcw_pkg::CTL_NL || cur_col > cols - 2) begin
        cur_row++;
        cur_col = 0;
      end else begin
        cur_col++;
      end
      // past the last row: copy rows up, last row keeps its content
      if (cur_row >= rows) begin
        for (int r = 1; r < rows; r++)
          for (int c = 0; c < cols; c++)
            glyphs[(r - 1) * ttcw_pkg::MAX_COLUMNS + c] = glyphs[r * ttcw_pkg::MAX_COLUMNS + c];
        cur_col = 0;
        cur_row--;
        n_scrolls++;
      end
    endfunction

    function void note_word(word_t w);
      result_t         want;
      ttcw_pkg::cell_t g;
      want = '0;
      if (w.action == ttcw_pkg::ACT_BYTE) begin
        n_bytes++;
        if (cur_col > cols_used() - 1) cur_col = cols_used() - 1;
        if (cur_row > rows_used() - 1) cur_row = rows_used() - 1;
        if (pend != 0) begin
          // any byte counts as a continuation here
          partial = {partial[9:0], w.byte_in[5:0]};
          pend--;
          if (pend == 0) put_and_move(partial, ttcw_pkg::CTL_NONE);
        end else if (w.byte_in != ttcw_pkg::ESC_BYTE) begin
          if (!w.byte_in[7]) begin
            put_and_move({8'h00, w.byte_in}, w.byte_in);
          end else if (w.byte_in[7:5] == 3'b110) begin
            partial = {11'd0, w.byte_in[4:0]};
            pend    = 1;
          end else if (w.byte_in[7:4] == 4'b1110) begin
            partial = {12'd0, w.byte_in[3:0]};
            pend    = 2;
          end else begin
            // stray continuation or invalid lead stores codepoint zero
            put_and_move(16'h0000, ttcw_pkg::CTL_NONE);
          end
        end
      end else begin
        n_reads++;
        g = glyphs[int'(w.read_row) * ttcw_pkg::MAX_COLUMNS + int'(w.read_col)];
        want.code   = g.code;
        want.fg     = g.fg;
        want.attr   = g.attr;
        want.rvalid = 1'b1;
      end
      want.col = ttcw_pkg::COL_BITS'(cur_col);
      want.row = ttcw_pkg::ROW_BITS'(cur_row);
      expected_q.push_back(want);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("result word with nothing outstanding: col %0d row %0d", got.col, got.row);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      n_checked++;
      check_field("cursor_col_out", 32'(want.col), 32'(got.col));
      check_field("cursor_row_out", 32'(want.row), 32'(got.row));
      check_field("cell_codepoint", 32'(want.code), 32'(got.code));
      check_field("cell_fg", want.fg, got.fg);
      check_field("cell_attributes", 32'(want.attr), 32'(got.attr));
      check_field("read_valid", 32'(want.rvalid), 32'(got.rvalid));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  ttcw_pkg::cfg_idx_e cfg_idx;
  logic [31:0]        cfg_data;
  int                 src_gap_pct;
  int                 snk_stall_pct;
  int                 idle_cycles;

  screen_scoreboard sb = new();

  ttcw_in_if  in_if ();
  ttcw_out_if out_if ();

  text_terminal_cell_writer_core uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // take result words and check them
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result({out_if.cursor_col_out, out_if.cursor_row_out, out_if.cell_codepoint,
                       out_if.cell_fg, out_if.cell_attributes, out_if.read_valid});
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no word accepted for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // drive one word, note it when it is taken; enters and leaves at a falling edge
  task automatic send_word(input word_t w);
    while (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.action   <= w.action;
    in_if.byte_in  <= w.byte_in;
    in_if.read_row <= w.read_row;
    in_if.read_col <= w.read_col;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_word(w);
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word({ttcw_pkg::ACT_BYTE, b, ttcw_pkg::ROW_BITS'($urandom),
               ttcw_pkg::COL_BITS'($urandom)});
  endtask

  task automatic send_read(input int row, input int col);
    send_word({ttcw_pkg::ACT_READ, 8'($urandom), ttcw_pkg::ROW_BITS'(row),
               ttcw_pkg::COL_BITS'(col)});
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(63));
  endfunction

  // let outstanding results drain before touching registers
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (IDLE_GAP) @(negedge clk);
  endtask

  task automatic write_reg(input ttcw_pkg::cfg_idx_e idx, input logic [31:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic set_geometry(input logic [7:0] cols, input logic [6:0] rows,
                              input logic [31:0] fg, input logic [7:0] attr);
    write_reg(ttcw_pkg::CFG_COLUMN_COUNT, 32'(cols));
    write_reg(ttcw_pkg::CFG_ROW_COUNT, 32'(rows));
    write_reg(ttcw_pkg::CFG_CURRENT_FG, fg);
    write_reg(ttcw_pkg::CFG_CURRENT_ATTR, 32'(attr));
  endtask

  // mostly small screens so scrolls stay short, sometimes the extremes
  task automatic pick_geometry();
    logic [7:0]  cols;
    logic [6:0]  rows;
    logic [31:0] fg;
    logic [7:0]  attr;
    case ($urandom_range(9))
      0: begin
        cols = 8'($urandom_range(1));
        rows = 7'd0;
      end
      1: begin
        cols = 8'($urandom_range(255, 128));
        rows = 7'($urandom_range(127, 64));
      end
      2: begin
        cols = 8'($urandom_range(128, 2));
        rows = 7'($urandom_range(64, 1));
      end
      default: begin
        cols = 8'($urandom_range(24, 2));
        rows = 7'($urandom_range(8, 1));
      end
    endcase
    case ($urandom_range(5))
      0: fg = 32'h0000_0000;
      1: fg = 32'hffff_ffff;
      default: fg = $urandom;
    endcase
    attr = ($urandom_range(5) == 0) ? 8'hff : 8'($urandom_range(255));
    set_geometry(cols, rows, fg, attr);
  endtask

  // one random chunk: mostly well-formed text and utf-8, some noise and reads
  task automatic send_random_chunk(output int counted);
    int pick;
    pick    = $urandom_range(99);
    counted = 1;
    if (pick < 38) begin
      send_byte(8'($urandom_range(8'h7e, 8'h20)));
    end else if (pick < 47) begin
      send_byte(ttcw_pkg::CTL_NL);
    end else if (pick < 52) begin
      send_byte(ttcw_pkg::CTL_TAB);
    end else if (pick < 57) begin
      send_byte(ttcw_pkg::CTL_BS);
    end else if (pick < 59) begin
      send_byte(ttcw_pkg::ESC_BYTE);
      counted = 0;
    end else if (pick < 67) begin
      send_byte(8'hc0 | 8'($urandom_range(31)));
      send_byte(cont_byte());
      counted = 2;
    end else if (pick < 75) begin
      send_byte(8'he0 | 8'($urandom_range(15)));
      send_byte(cont_byte());
      send_byte(cont_byte());
      counted = 3;
    end else if (pick < 79) begin
      // broken sequence: lead followed by any byte
      send_byte($urandom_range(1) ? 8'hc0 | 8'($urandom_range(31))
                                  : 8'he0 | 8'($urandom_range(15)));
      send_byte(8'($urandom_range(255)));
      counted = 2;
    end else if (pick < 83) begin
      send_byte($urandom_range(1) ? 8'($urandom_range(8'hbf, 8'h80))
                                  : 8'($urandom_range(8'hff, 8'hf0)));
    end else if (pick < 87) begin
      send_byte(8'($urandom_range(255)));
    end else if ($urandom_range(3) == 0) begin
      send_read($urandom_range(ttcw_pkg::MAX_ROWS - 1),
                $urandom_range(ttcw_pkg::MAX_COLUMNS - 1));
    end else begin
      send_read($urandom_range(sb.rows_used() - 1), $urandom_range(sb.cols_used() - 1));
    end
  endtask

  initial begin
    int sent;
    int counted;

    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = ttcw_pkg::CFG_COLUMN_COUNT;
    cfg_data        = '0;
    in_if.valid     = 1'b0;
    in_if.action    = ttcw_pkg::ACT_BYTE;
    in_if.byte_in   = '0;
    in_if.read_row  = '0;
    in_if.read_col  = '0;
    out_if.ready    = 1'b0;
    src_gap_pct     = 8;
    snk_stall_pct   = 60;
    idle_cycles     = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset geometry, byte classes, utf-8 forms and invalid leads
    send_read(0, 0);
    send_byte(8'h41);
    send_byte(8'h00);
    send_byte(8'h7f);
    send_byte(ttcw_pkg::ESC_BYTE);
    send_byte(8'hc3);
    send_byte(8'ha9);
    send_byte(8'he2);
    send_byte(8'h82);
    send_byte(8'hac);
    send_byte(8'hef);
    send_byte(8'hbf);
    send_byte(8'hbf);
    // escape taken as a continuation
    send_byte(8'hc2);
    send_byte(ttcw_pkg::ESC_BYTE);
    send_byte(8'h80);
    send_byte(8'hbf);
    send_byte(8'hf0);
    send_byte(8'hff);
    send_byte(ttcw_pkg::CTL_TAB);
    send_byte(ttcw_pkg::CTL_NL);
    // backspace at column zero saturates
    send_byte(ttcw_pkg::CTL_BS);
    send_byte(8'h78);
    send_byte(ttcw_pkg::CTL_BS);
    send_read(0, 3);
    send_read(0, 15);
    send_read(ttcw_pkg::MAX_ROWS - 1, ttcw_pkg::MAX_COLUMNS - 1);

    // geometry below range clamps to 2 x 1: wrap, scroll and tab clamp
    wait_idle();
    set_geometry(8'd0, 7'd0, 32'hffff_ffff, 8'hff);
    send_byte(8'h61);
    send_byte(ttcw_pkg::CTL_TAB);
    send_byte(ttcw_pkg::CTL_BS);
    send_read(0, 0);
    send_read(0, 1);

    // geometry above range, then shrink so the cursor sits outside the area
    wait_idle();
    set_geometry(8'd255, 7'd127, 32'h0000_0000, 8'h00);
    repeat (6) send_byte(ttcw_pkg::CTL_NL);
    repeat (6) send_byte(ttcw_pkg::CTL_TAB);
    wait_idle();
    set_geometry(8'd5, 7'd3, 32'h1234_5678, 8'h5a);
    send_byte(8'h71);
    send_read(1, 4);
    send_read(2, 4);

    // random part over three idling modes
    for (int mode = 0; mode < 3; mode++) begin
      for (int phase = 0; phase < 4; phase++) begin
        wait_idle();
        case (mode)
          0: begin
            src_gap_pct   = 8;
            snk_stall_pct = 60;
          end
          1: begin
            src_gap_pct   = 60;
            snk_stall_pct = 8;
          end
          default: begin
            src_gap_pct   = 0;
            snk_stall_pct = 0;
          end
        endcase
        pick_geometry();
        sent = 0;
        while (sent < WORDS_PER_PHASE) begin
          send_random_chunk(counted);
          sent += counted;
        end
      end
    end

    wait_idle();
    $display("covered %0d byte words and %0d cell reads, %0d scrolls predicted",
             sb.n_bytes, sb.n_reads, sb.n_scrolls);
    $display("%0d result words checked, %0d mismatches", sb.n_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
